FILE: src/puct_pkg.sv
// shared types for the puct child select block
`default_nettype none
package puct_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT,
    S_SQRT_W,
    S_CHECK,
    S_MUL1,
    S_MUL2,
    S_QDIV,
    S_QDIV_W,
    S_UDIV,
    S_UDIV_W,
    S_UPD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic start_sqrt;
    logic save_sqrt;
    logic set_ovf;
    logic pos_inc;
    logic mul1;
    logic mul2;
    logic q_zero;
    logic start_qdiv;
    logic save_q;
    logic start_udiv;
    logic save_u;
    logic update;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic at_limit;
    logic term;
    logic last;
    logic cv_zero;
    logic unit_idle;
    logic out_free;
  } stat_t;

  localparam int SQRT_STEPS = 20;
  localparam int DIV_STEPS  = 60;
  localparam logic [23:0] EW_RESET = 24'd65536;

endpackage
`default_nettype wire

FILE: src/puct_child_select.sv
// PUCT child select: scores a run of children one request at a time and
// reports the best open child after the last one. Requests are taken one at a
// time; an open child runs a value divide and an exploration divide, the value
// divide is skipped when the child has no visits, and the first child of a run
// also computes the parent square root, all on one shared bit-serial unit.
// Terminal and over-limit children skip the scoring. A last child also waits
// while the output register is still full. The result sits in an output
// register, so a following run proceeds until its own last child.
`default_nettype none
module puct_child_select #(
  parameter int MAX_CHILDREN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [23:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [23:0]        in_parent_visits,
  input  wire logic [23:0]        in_child_visits,
  input  wire logic signed [39:0] in_child_value_sum,
  input  wire logic [15:0]        in_child_prior,
  input  wire logic               in_child_terminal,
  input  wire logic               in_last_child,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [5:0]              out_best_index,
  output logic                    out_any_open,
  output logic                    out_too_many
);
  import puct_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  puct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  puct_datapath #(.MAX_CHILDREN(MAX_CHILDREN)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_parent_visits   (in_parent_visits),
    .in_child_visits    (in_child_visits),
    .in_child_value_sum (in_child_value_sum),
    .in_child_prior     (in_child_prior),
    .in_child_terminal  (in_child_terminal),
    .in_last_child      (in_last_child),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_best_index     (out_best_index),
    .out_any_open       (out_any_open),
    .out_too_many       (out_too_many)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_sqrt || cmd.start_qdiv || cmd.start_udiv |-> stat.unit_idle)
    else $error("iterative unit restarted while running");

  a_none_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_open |-> out_best_index == 6'd0)
    else $error("index given with no open child");

endmodule
`default_nettype wire

FILE: src/puct_ctrl.sv
// controller state machine sequencing one child request
`default_nettype none
module puct_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire puct_pkg::stat_t stat,
  output puct_pkg::cmd_t      cmd
);
  import puct_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = stat.first ? S_SQRT : S_CHECK;
      S_SQRT:   state_nxt = S_SQRT_W;
      S_SQRT_W: if (stat.unit_idle) state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.at_limit || stat.term) state_nxt = S_FIN;
        else state_nxt = S_MUL1;
      end
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_QDIV;
      S_QDIV:   state_nxt = stat.cv_zero ? S_UDIV : S_QDIV_W;
      S_QDIV_W: if (stat.unit_idle) state_nxt = S_UDIV;
      S_UDIV:   state_nxt = S_UDIV_W;
      S_UDIV_W: if (stat.unit_idle) state_nxt = S_UPD;
      S_UPD:    state_nxt = S_FIN;
      S_FIN:    if (!stat.last || stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SQRT:   cmd.start_sqrt = 1'b1;
      S_SQRT_W: cmd.save_sqrt = stat.unit_idle;
      S_CHECK: begin
        if (stat.at_limit) cmd.set_ovf = 1'b1;
        else if (stat.term) cmd.pos_inc = 1'b1;
      end
      S_MUL1:   cmd.mul1 = 1'b1;
      S_MUL2:   cmd.mul2 = 1'b1;
      S_QDIV: begin
        if (stat.cv_zero) cmd.q_zero = 1'b1;
        else cmd.start_qdiv = 1'b1;
      end
      S_QDIV_W: cmd.save_q = stat.unit_idle;
      S_UDIV:   cmd.start_udiv = 1'b1;
      S_UDIV_W: cmd.save_u = stat.unit_idle;
      S_UPD: begin
        cmd.update  = 1'b1;
        cmd.pos_inc = 1'b1;
      end
      S_FIN:    cmd.emit = stat.last && stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/puct_datapath.sv
// datapath: shared sqrt/divide unit, multipliers, best tracking, output register
`default_nettype none
module puct_datapath #(
  parameter int MAX_CHILDREN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [23:0]        cfg_wr_data,
  input  wire logic [23:0]        in_parent_visits,
  input  wire logic [23:0]        in_child_visits,
  input  wire logic signed [39:0] in_child_value_sum,
  input  wire logic [15:0]        in_child_prior,
  input  wire logic               in_child_terminal,
  input  wire logic               in_last_child,
  input  wire puct_pkg::cmd_t     cmd,
  output puct_pkg::stat_t         stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [5:0]              out_best_index,
  output logic                    out_any_open,
  output logic                    out_too_many
);
  import puct_pkg::*;

  localparam int PW = $clog2(MAX_CHILDREN + 1);

  logic [23:0]        ew_r;
  logic [23:0]        pv_r, cv_r;
  logic signed [39:0] sum_r;
  logic [15:0]        prior_r;
  logic               term_r, last_r;
  logic [19:0]        sqrt_r;
  logic [39:0]        mul1_r;
  logic [59:0]        prod_r;
  logic signed [47:0] q_r, u_r, best_r;
  logic [PW-1:0]      pos_r;
  logic [5:0]         best_pos_r;
  logic               found_r, ovf_r;
  logic               out_valid_r, out_any_r, out_many_r;
  logic [5:0]         out_idx_r;

  // iterative unit
  logic [59:0] num_r, quo_r;
  logic [26:0] rem_r;
  logic [24:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        sq_mode_r;
  logic [26:0] rem_sh, sub;
  logic        ge;
  logic [39:0] mag;
  logic signed [47:0] score;
  logic        take;

  assign rem_sh = sq_mode_r ? {rem_r[24:0], num_r[59:58]} : {rem_r[25:0], num_r[59]};
  assign sub    = sq_mode_r ? 27'({quo_r[19:0], 2'b01}) : 27'(dvs_r);
  assign ge     = rem_sh >= sub;
  assign mag    = sum_r[39] ? 40'(-sum_r) : 40'(sum_r);
  assign score  = q_r + u_r;
  assign take   = !found_r || (score > best_r);

  always_comb begin
    stat.first     = pos_r == '0;
    stat.at_limit  = 32'(pos_r) >= MAX_CHILDREN;
    stat.term      = term_r;
    stat.last      = last_r;
    stat.cv_zero   = cv_r == '0;
    stat.unit_idle = cnt_r == '0;
    stat.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ew_r        <= EW_RESET;
      cnt_r       <= '0;
      pos_r       <= '0;
      found_r     <= 1'b0;
      ovf_r       <= 1'b0;
      sqrt_r      <= '0;
      best_r      <= '0;
      best_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) ew_r <= cfg_wr_data;
      if (cmd.start_sqrt) cnt_r <= 6'(SQRT_STEPS);
      else if (cmd.start_qdiv || cmd.start_udiv) cnt_r <= 6'(DIV_STEPS);
      else if (cnt_r != '0) cnt_r <= cnt_r - 6'd1;
      if (cmd.save_sqrt) sqrt_r <= quo_r[19:0];
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.update && take) begin
        best_r     <= score;
        best_pos_r <= 6'(pos_r);
        found_r    <= 1'b1;
      end
      if (cmd.pos_inc) pos_r <= pos_r + PW'(1);
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        sqrt_r      <= '0;
        best_r      <= '0;
        best_pos_r  <= '0;
        pos_r       <= '0;
        found_r     <= 1'b0;
        ovf_r       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pv_r    <= in_parent_visits;
      cv_r    <= in_child_visits;
      sum_r   <= in_child_value_sum;
      prior_r <= in_child_prior;
      term_r  <= in_child_terminal;
      last_r  <= in_last_child;
    end
    if (cmd.mul1) mul1_r <= 40'(ew_r) * 40'(prior_r);
    if (cmd.mul2) prod_r <= 60'(mul1_r) * 60'(sqrt_r);
    if (cmd.q_zero) q_r <= '0;
    if (cmd.save_q) q_r <= sum_r[39] ? -48'(quo_r[39:0]) : 48'(quo_r[39:0]);
    if (cmd.save_u) u_r <= 48'(quo_r[59:24]);
    if (cmd.start_sqrt) begin
      num_r     <= {pv_r, 16'd0, 20'd0};
      quo_r     <= '0;
      rem_r     <= '0;
      sq_mode_r <= 1'b1;
    end else if (cmd.start_qdiv) begin
      num_r     <= 60'(mag);
      dvs_r     <= {1'b0, cv_r};
      quo_r     <= '0;
      rem_r     <= '0;
      sq_mode_r <= 1'b0;
    end else if (cmd.start_udiv) begin
      num_r     <= prod_r;
      dvs_r     <= 25'(cv_r) + 25'd1;
      quo_r     <= '0;
      rem_r     <= '0;
      sq_mode_r <= 1'b0;
    end else if (cnt_r != '0) begin
      num_r <= sq_mode_r ? {num_r[57:0], 2'b00} : {num_r[58:0], 1'b0};
      rem_r <= ge ? rem_sh - sub : rem_sh;
      quo_r <= {quo_r[58:0], ge};
    end
    if (cmd.emit) begin
      out_idx_r  <= found_r ? best_pos_r : 6'd0;
      out_any_r  <= found_r;
      out_many_r <= ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_index = out_idx_r;
  assign out_any_open   = out_any_r;
  assign out_too_many   = out_many_r;

endmodule
`default_nettype wire
